### rtl/core/joystick_axis_deviation_percent_assert.svh
// Assertion macros for the joystick axis deviation block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef JOYSTICK_AXIS_DEVIATION_PERCENT_ASSERT_SVH
`define JOYSTICK_AXIS_DEVIATION_PERCENT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define JADP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define JADP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/jadp_pkg.sv
// Shared types and constants of the joystick axis deviation block.
// No dependencies; imported by every module of the block.
`default_nettype none
package jadp_pkg;

  localparam int SAMPLE_W = 12;
  localparam int NUM_W    = 19;   // (sample span) * 100 fits here
  localparam int Q_W      = 7;    // quotient bits kept before saturation
  localparam int PCT_W    = 8;
  localparam int PCT_MAX  = 100;
  localparam int IDX_W    = 3;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_IDLE_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IDLE_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_Y   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_X   = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Y   = 3'd5;
  localparam logic [IDX_W-1:0] REG_USE_CAL = 3'd6;

  // Per-word control bits that ride along the pipe
  typedef struct packed {
    logic zero;   // result forced to 0
    logic down;   // sample below idle: result is q - 100
    logic ovf;    // quotient reached 128 or more
  } ctl_t;

endpackage
`default_nettype wire

### rtl/core/jadp_prep.sv
// Front stage: axis select, clamp, span and divisor setup, numerator * 100.
// Depends on jadp_pkg.
`default_nettype none
module jadp_prep #(
  parameter int unsigned ADC_FULL_SCALE = 4095,
  parameter int DW = 12,
  parameter int RW = 19
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          axis_sel,
  input  wire logic [jadp_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [jadp_pkg::SAMPLE_W-1:0] idle_x,
  input  wire logic [jadp_pkg::SAMPLE_W-1:0] idle_y,
  input  wire logic [jadp_pkg::SAMPLE_W-1:0] min_x,
  input  wire logic [jadp_pkg::SAMPLE_W-1:0] min_y,
  input  wire logic [jadp_pkg::SAMPLE_W-1:0] max_x,
  input  wire logic [jadp_pkg::SAMPLE_W-1:0] max_y,
  input  wire logic                          use_cal,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [RW-1:0]                      rem,
  output logic [DW-1:0]                      den,
  output logic [jadp_pkg::Q_W-1:0]           quo,
  output jadp_pkg::ctl_t                     ctl
);
  import jadp_pkg::*;

  logic [SAMPLE_W-1:0] idle, lo, hi, cur, base, diff;
  logic [DW-1:0]       top_v, idle_w, den_nxt;
  logic                up, den_ok;
  logic [NUM_W-1:0]    num;
  ctl_t                ctl_nxt;

  logic                valid_r;
  logic [RW-1:0]       rem_r;
  logic [DW-1:0]       den_r;
  ctl_t                ctl_r;

  // Pick the axis, clamp in calibrated mode, choose the span
  always_comb begin
    idle   = axis_sel ? idle_y : idle_x;
    lo     = axis_sel ? min_y : min_x;
    hi     = axis_sel ? max_y : max_x;
    cur    = (use_cal && (sample < lo)) ? lo : sample;
    base   = use_cal ? lo : '0;
    top_v  = use_cal ? DW'(hi) : DW'(ADC_FULL_SCALE);
    idle_w = DW'(idle);
    up     = cur >= idle;
    if (up) begin
      diff    = cur - idle;
      den_ok  = top_v > idle_w;
      den_nxt = top_v - idle_w;
    end else begin
      diff    = cur - base;
      den_ok  = idle > base;
      den_nxt = DW'(idle - base);
    end
    num          = NUM_W'(diff) * NUM_W'(PCT_MAX);
    ctl_nxt.zero = (use_cal && (hi == '0)) || !den_ok;
    ctl_nxt.down = !up;
    ctl_nxt.ovf  = 1'b0;
  end

  assign in_ready = !valid_r || out_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      rem_r <= RW'(num);
      den_r <= den_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign out_valid = valid_r;
  assign rem       = rem_r;
  assign den       = den_r;
  assign quo       = '0;
  assign ctl       = ctl_r;
endmodule
`default_nettype wire

### rtl/core/jadp_div_stage.sv
// One stage of the restoring divider: a few quotient bits per stage,
// optionally with the quotient-overflow check. Depends on jadp_pkg.
`default_nettype none
module jadp_div_stage #(
  parameter int DW = 12,
  parameter int RW = 19,
  parameter int QHI = 6,
  parameter int NB = 2,
  parameter bit CHK_OVF = 1'b0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [RW-1:0]           rem_i,
  input  wire logic [DW-1:0]           den_i,
  input  wire logic [jadp_pkg::Q_W-1:0] quo_i,
  input  wire jadp_pkg::ctl_t          ctl_i,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [RW-1:0]                rem_o,
  output logic [DW-1:0]                den_o,
  output logic [jadp_pkg::Q_W-1:0]     quo_o,
  output jadp_pkg::ctl_t               ctl_o
);
  import jadp_pkg::*;

  logic [RW-1:0]  rem_nxt;
  logic [Q_W-1:0] quo_nxt;
  ctl_t           ctl_nxt;

  logic           valid_r;
  logic [RW-1:0]  rem_r;
  logic [DW-1:0]  den_r;
  logic [Q_W-1:0] quo_r;
  ctl_t           ctl_r;

  // Compare and subtract, one quotient bit per step
  always_comb begin
    logic [RW-1:0] sh;
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    ctl_nxt = ctl_i;
    if (CHK_OVF) begin
      ctl_nxt.ovf = rem_i >= (RW'(den_i) << Q_W);
    end
    for (int i = 0; i < NB; i++) begin
      sh = RW'(den_i) << (QHI - i);
      if (rem_nxt >= sh) begin
        rem_nxt          = rem_nxt - sh;
        quo_nxt[QHI - i] = 1'b1;
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      quo_r <= quo_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign out_valid = valid_r;
  assign rem_o     = rem_r;
  assign den_o     = den_r;
  assign quo_o     = quo_r;
  assign ctl_o     = ctl_r;
endmodule
`default_nettype wire

### rtl/core/jadp_out.sv
// Output stage: sign, saturation and the result register.
// Depends on jadp_pkg.
`default_nettype none
module jadp_out (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [jadp_pkg::Q_W-1:0] quo_i,
  input  wire jadp_pkg::ctl_t           ctl_i,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [jadp_pkg::PCT_W-1:0]    percent
);
  import jadp_pkg::*;

  logic [PCT_W-1:0] pct_nxt;
  logic             valid_r;
  logic [PCT_W-1:0] pct_r;

  // Zero flag: 0; below idle: q - 100; above: q, capped at 100
  always_comb begin
    if (ctl_i.zero) begin
      pct_nxt = '0;
    end else if (ctl_i.down) begin
      pct_nxt = PCT_W'(quo_i) - PCT_W'(PCT_MAX);
    end else if (ctl_i.ovf || (PCT_W'(quo_i) > PCT_W'(PCT_MAX))) begin
      pct_nxt = PCT_W'(PCT_MAX);
    end else begin
      pct_nxt = PCT_W'(quo_i);
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      pct_r <= pct_nxt;
    end
  end

  assign out_valid = valid_r;
  assign percent   = pct_r;
endmodule
`default_nettype wire

### rtl/core/joystick_axis_deviation_percent.sv
// Joystick axis deviation: one ADC word in, one signed percent word out.
// Throughput is one word per clock unless the output stalls. A word passes the
// setup stage, four restoring-divider stages (overflow check plus one
// quotient bit, then two bits each) and the output register. Each stage holds
// its word under backpressure and fills bubbles, so input is still taken while
// a result waits. The user must write configuration registers through cfg_we,
// cfg_index, cfg_wdata only while no word is in flight; the block does not check.
// Depends on jadp_pkg, jadp_prep, jadp_div_stage, jadp_out and the assert header.
`default_nettype none
`include "joystick_axis_deviation_percent_assert.svh"
module joystick_axis_deviation_percent #(
  parameter int unsigned ADC_FULL_SCALE = 4095
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // in_tdata: [11:0] sample, [15:12] zero
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [15:0]                 in_tdata,
  // in_tuser: [0] axis_sel
  input  wire logic                        in_tuser,
  // out_tdata: [7:0] percent
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [jadp_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [jadp_pkg::SAMPLE_W-1:0] cfg_wdata
);
  import jadp_pkg::*;

  localparam int FSW = $clog2(ADC_FULL_SCALE + 1);
  localparam int DW  = (FSW > SAMPLE_W) ? FSW : SAMPLE_W;
  localparam int RW  = ((DW + Q_W) > NUM_W) ? (DW + Q_W) : NUM_W;
  localparam int NST = 4;

  logic [SAMPLE_W-1:0] idle_x_r, idle_y_r, min_x_r, min_y_r, max_x_r, max_y_r;
  logic                use_cal_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_x_r  <= SAMPLE_W'(2048);
      idle_y_r  <= SAMPLE_W'(2048);
      min_x_r   <= '0;
      min_y_r   <= '0;
      max_x_r   <= '0;
      max_y_r   <= '0;
      use_cal_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_X:  idle_x_r  <= cfg_wdata;
        REG_IDLE_Y:  idle_y_r  <= cfg_wdata;
        REG_MIN_X:   min_x_r   <= cfg_wdata;
        REG_MIN_Y:   min_y_r   <= cfg_wdata;
        REG_MAX_X:   max_x_r   <= cfg_wdata;
        REG_MAX_Y:   max_y_r   <= cfg_wdata;
        REG_USE_CAL: use_cal_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage links: index 0 is the setup stage, 1..NST the divider stages
  logic           v   [NST+1];
  logic           rdy [NST+1];
  logic [RW-1:0]  rem [NST+1];
  logic [DW-1:0]  den [NST+1];
  logic [Q_W-1:0] quo [NST+1];
  ctl_t           ctl [NST+1];
  logic           out_rdy;

  jadp_prep #(
    .ADC_FULL_SCALE(ADC_FULL_SCALE), .DW(DW), .RW(RW)
  ) u_prep (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .axis_sel(in_tuser), .sample(in_tdata[SAMPLE_W-1:0]),
    .idle_x(idle_x_r), .idle_y(idle_y_r),
    .min_x(min_x_r), .min_y(min_y_r),
    .max_x(max_x_r), .max_y(max_y_r),
    .use_cal(use_cal_r),
    .out_valid(v[0]), .out_ready(rdy[0]),
    .rem(rem[0]), .den(den[0]), .quo(quo[0]), .ctl(ctl[0])
  );

  // Divider: overflow check and bit 6, then bits 5..4, 3..2, 1..0
  for (genvar s = 1; s <= NST; s++) begin : g_div
    localparam int QHI = (s == 1) ? (Q_W - 1) : (Q_W - 2 * s + 2);
    localparam int NB  = (s == 1) ? 1 : 2;
    jadp_div_stage #(
      .DW(DW), .RW(RW), .QHI(QHI), .NB(NB), .CHK_OVF(s == 1)
    ) u_div (
      .clk(clk), .rst_n(rst_n),
      .in_valid(v[s-1]), .in_ready(rdy[s-1]),
      .rem_i(rem[s-1]), .den_i(den[s-1]), .quo_i(quo[s-1]), .ctl_i(ctl[s-1]),
      .out_valid(v[s]), .out_ready(rdy[s]),
      .rem_o(rem[s]), .den_o(den[s]), .quo_o(quo[s]), .ctl_o(ctl[s])
    );
  end

  assign rdy[NST] = out_rdy;

  jadp_out u_out (
    .clk(clk), .rst_n(rst_n),
    .in_valid(v[NST]), .in_ready(out_rdy),
    .quo_i(quo[NST]), .ctl_i(ctl[NST]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .percent(out_tdata)
  );

  // Checks
  `JADP_ASSERT_IMP(a_pct_range, out_tvalid,
    ($signed(out_tdata) <= 8'sd100) && ($signed(out_tdata) >= -8'sd100),
    "percent out of range")
  `JADP_ASSERT_IMP(a_down_no_ovf, v[NST] && !ctl[NST].zero && ctl[NST].down,
    !ctl[NST].ovf && (quo[NST] < Q_W'(PCT_MAX)),
    "below-idle quotient not under 100")
  `JADP_ASSERT_IMP(a_stall_full, !in_tready,
    v[0] && v[1] && v[2] && v[3] && v[4] && out_tvalid,
    "input stalled with a bubble in the pipe")
  `JADP_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready && v[NST],
    v[NST] && $stable(quo[NST]),
    "word lost ahead of a stalled output")

endmodule
`default_nettype wire
